[rtl/core/tksd_pkg.sv]
// Types and constants shared by the terminal key sequence decoder.
`timescale 1ns / 1ps

package tksd_pkg;

  localparam int unsigned WinDepth   = 5;
  localparam int unsigned MaxEvents  = 4;

  localparam logic [7:0] ChEsc       = 8'h1B;
  localparam logic [7:0] ChLBrack    = 8'h5B;
  localparam logic [7:0] ChUpperO    = 8'h4F;
  localparam logic [7:0] ChTilde     = 8'h7E;
  localparam logic [7:0] ChOne       = 8'h31;
  localparam logic [7:0] ChFive      = 8'h35;
  localparam logic [7:0] ChUpperP    = 8'h50;
  localparam logic [7:0] ChUpperS    = 8'h53;
  localparam logic [7:0] ChCtrlC     = 8'h03;
  localparam logic [7:0] ChCtrlD     = 8'h04;
  localparam logic [7:0] ChCtrlU     = 8'h15;
  localparam logic [7:0] ChCtrlL     = 8'h0C;
  localparam logic [7:0] ChCtrlR     = 8'h12;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChDel       = 8'h7F;
  localparam logic [7:0] ChBs        = 8'h08;
  localparam logic [7:0] ChTab       = 8'h09;

  localparam logic [4:0] KeyChar     = 5'd0;
  localparam logic [4:0] KeyEscape   = 5'd1;
  localparam logic [4:0] KeyUp       = 5'd2;
  localparam logic [4:0] KeyDown     = 5'd3;
  localparam logic [4:0] KeyRight    = 5'd4;
  localparam logic [4:0] KeyLeft     = 5'd5;
  localparam logic [4:0] KeyHome     = 5'd6;
  localparam logic [4:0] KeyEnd      = 5'd7;
  localparam logic [4:0] KeyDelete   = 5'd8;
  localparam logic [4:0] KeyPgUp     = 5'd9;
  localparam logic [4:0] KeyPgDn     = 5'd10;
  localparam logic [4:0] KeyF1       = 5'd11;
  localparam logic [4:0] KeyF5       = 5'd15;
  localparam logic [4:0] KeyCtrlC    = 5'd16;
  localparam logic [4:0] KeyCtrlD    = 5'd17;
  localparam logic [4:0] KeyCtrlU    = 5'd18;
  localparam logic [4:0] KeyCtrlL    = 5'd19;
  localparam logic [4:0] KeyCtrlR    = 5'd20;
  localparam logic [4:0] KeyEnter    = 5'd21;
  localparam logic [4:0] KeyBksp     = 5'd22;
  localparam logic [4:0] KeyTab      = 5'd23;

  typedef logic [WinDepth-1:0][7:0] win_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       burst_end;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  key_code;
    logic [20:0] code_point;
    logic        alt_flag;
    logic        ctrl_flag;
    logic        last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [4:0]  key_code;
    logic [20:0] code_point;
    logic        alt_flag;
    logic        ctrl_flag;
  } event_t;

  typedef struct packed {
    logic       brk;
    logic       emit;
    logic [2:0] adv;
    event_t     ev;
  } dec_t;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
    logic move;
    logic last;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic brk;
    logic emit;
    logic held_vld;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/terminal_key_sequence_decoder.sv]
// Top level of the terminal key sequence decoder.
//
//   port group   dir   handshake              payload
//   in_*         in    in_valid_i/in_ready_o  tksd_pkg::in_beat_t  (in_byte, burst_end)
//   out_*        out   out_valid_o/out_ready_i tksd_pkg::out_beat_t (one key event)
//
// One input beat is loaded, then parsed with one step per decoded token, then the parse
// is closed and the flush state moves out any event that is still held.
// The parse loop emits at most one event per cycle through a single held-event stage.
// Reset clears the pending count, the held-event valid flag and the output valid.
// A stalled output holds the parse step that would overwrite the held event.
`timescale 1ns / 1ps

module terminal_key_sequence_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tksd_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tksd_pkg::out_beat_t out_data_o
);
  import tksd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tksd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tksd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/core/tksd_dec.sv]
// Token decoder: classifies the sequence at the head of the byte window.
`timescale 1ns / 1ps

module tksd_dec (
  input  tksd_pkg::win_t win_i,
  input  logic [2:0]     len_i,
  input  logic           fin_i,
  output tksd_pkg::dec_t dec_o
);
  import tksd_pkg::*;

  function automatic logic [4:0] cursor_key(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h41:   k = KeyUp;
      8'h42:   k = KeyDown;
      8'h43:   k = KeyRight;
      8'h44:   k = KeyLeft;
      8'h48:   k = KeyHome;
      8'h46:   k = KeyEnd;
      default: k = KeyChar;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] tilde_key(input logic [7:0] c);
    logic [4:0] k;
    unique case (c) inside
      8'h31, 8'h37: k = KeyHome;
      8'h34, 8'h38: k = KeyEnd;
      8'h33:        k = KeyDelete;
      8'h35:        k = KeyPgUp;
      8'h36:        k = KeyPgDn;
      default:      k = KeyChar;
    endcase
    return k;
  endfunction

  logic [7:0] b0, b1, b2, b3, b4;
  logic [4:0] ck, tk;
  logic [2:0] need;

  assign b0 = win_i[0];
  assign b1 = win_i[1];
  assign b2 = win_i[2];
  assign b3 = win_i[3];
  assign b4 = win_i[4];
  assign ck = cursor_key(b2);
  assign tk = tilde_key(b2);

  always_comb begin
    dec_o = '0;
    dec_o.adv = 3'd1;
    need = 3'd1;
    if (b0 == ChEsc) begin
      if (len_i < 3'd2) begin
        if (!fin_i) begin
          dec_o.brk = 1'b1;
        end else begin
          dec_o.emit = 1'b1;
          dec_o.ev.key_code = KeyEscape;
        end
      end else if (b1 == ChLBrack || b1 == ChUpperO) begin
        if (len_i < 3'd3) begin
          if (!fin_i) begin
            dec_o.brk = 1'b1;
          end else begin
            dec_o.emit = 1'b1;
            dec_o.ev.key_code = KeyEscape;
          end
        end else if (ck != KeyChar) begin
          dec_o.emit = 1'b1;
          dec_o.ev.key_code = ck;
          dec_o.adv = 3'd3;
        end else if (b1 == ChUpperO) begin
          dec_o.adv = 3'd3;
          if (b2 >= ChUpperP && b2 <= ChUpperS) begin
            dec_o.emit = 1'b1;
            dec_o.ev.key_code = KeyF1 + {3'b000, b2[1:0]};
          end
        end else if (len_i < 3'd4) begin
          if (!fin_i) begin
            dec_o.brk = 1'b1;
          end else begin
            dec_o.adv = 3'd3;
          end
        end else if (b3 == ChTilde && tk != KeyChar) begin
          dec_o.emit = 1'b1;
          dec_o.ev.key_code = tk;
          dec_o.adv = 3'd4;
        end else if (len_i < 3'd5) begin
          if (!fin_i) begin
            dec_o.brk = 1'b1;
          end else begin
            dec_o.adv = 3'd3;
          end
        end else if (b4 == ChTilde) begin
          dec_o.adv = 3'd5;
          if (b2 == ChOne && b3 == ChFive) begin
            dec_o.emit = 1'b1;
            dec_o.ev.key_code = KeyF5;
          end
        end else begin
          dec_o.adv = 3'd3;
        end
      end else begin
        dec_o.emit = 1'b1;
        dec_o.ev.key_code = KeyChar;
        dec_o.ev.code_point = {13'd0, b1};
        dec_o.ev.alt_flag = 1'b1;
        dec_o.adv = 3'd2;
      end
    end else if (b0 == ChCtrlC || b0 == ChCtrlD || b0 == ChCtrlU ||
                 b0 == ChCtrlL || b0 == ChCtrlR) begin
      dec_o.emit = 1'b1;
      dec_o.ev.ctrl_flag = 1'b1;
      unique case (b0)
        ChCtrlC: dec_o.ev.key_code = KeyCtrlC;
        ChCtrlD: dec_o.ev.key_code = KeyCtrlD;
        ChCtrlU: dec_o.ev.key_code = KeyCtrlU;
        ChCtrlL: dec_o.ev.key_code = KeyCtrlL;
        default: dec_o.ev.key_code = KeyCtrlR;
      endcase
    end else if (b0 == ChCr || b0 == ChLf) begin
      dec_o.emit = 1'b1;
      dec_o.ev.key_code = KeyEnter;
    end else if (b0 == ChDel || b0 == ChBs) begin
      dec_o.emit = 1'b1;
      dec_o.ev.key_code = KeyBksp;
    end else if (b0 == ChTab) begin
      dec_o.emit = 1'b1;
      dec_o.ev.key_code = KeyTab;
    end else begin
      if (b0[7:5] == 3'b110) begin
        need = 3'd2;
      end else if (b0[7:4] == 4'b1110) begin
        need = 3'd3;
      end else if (b0[7:3] == 5'b11110) begin
        need = 3'd4;
      end
      if (len_i < need) begin
        if (!fin_i) begin
          dec_o.brk = 1'b1;
        end
        need = 3'd1;
      end
      if (!dec_o.brk) begin
        dec_o.emit = 1'b1;
        dec_o.ev.key_code = KeyChar;
        dec_o.adv = need;
        unique case (need)
          3'd2:    dec_o.ev.code_point = {10'd0, b0[4:0], b1[5:0]};
          3'd3:    dec_o.ev.code_point = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
          3'd4:    dec_o.ev.code_point = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
          default: dec_o.ev.code_point = {13'd0, b0};
        endcase
      end
    end
  end

endmodule

[rtl/core/tksd_dp.sv]
// Datapath: byte window, held event and output register.
`timescale 1ns / 1ps

module tksd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tksd_pkg::cmd_t      cmd_i,
  output tksd_pkg::sts_t      sts_o,
  input  tksd_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tksd_pkg::out_beat_t out_data_o
);
  import tksd_pkg::*;

  win_t      win_q, win_d;
  logic [2:0] len_q, len_d;
  logic      fin_q;
  event_t    held_q;
  logic      held_vld_q;
  out_beat_t out_q;
  logic      out_vld_q;
  dec_t      dec;
  logic [3:0] src;

  tksd_dec u_dec (
    .win_i (win_q),
    .len_i (len_q),
    .fin_i (fin_q),
    .dec_o (dec)
  );

  always_comb begin
    win_d = win_q;
    len_d = len_q;
    src   = '0;
    if (cmd_i.load) begin
      for (int j = 0; j < WinDepth; j++) begin
        if (len_q == 3'(j)) begin
          win_d[j] = in_data_i.in_byte;
        end
      end
      len_d = len_q + 3'd1;
    end else if (cmd_i.step) begin
      for (int j = 0; j < WinDepth; j++) begin
        src = 4'(j) + {1'b0, dec.adv};
        if (src < 4'(WinDepth)) begin
          win_d[j] = win_q[src[2:0]];
        end
      end
      len_d = len_q - dec.adv;
    end else if (cmd_i.finish && fin_q) begin
      len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      fin_q      <= 1'b0;
      held_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      len_q <= len_d;
      if (cmd_i.load) begin
        fin_q <= in_data_i.burst_end;
      end
      if (cmd_i.capture) begin
        held_vld_q <= 1'b1;
      end else if (cmd_i.move) begin
        held_vld_q <= 1'b0;
      end
      if (cmd_i.move) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (cmd_i.capture) begin
      held_q <= dec.ev;
    end
    if (cmd_i.move) begin
      out_q <= {held_q, cmd_i.last};
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.len_zero = (len_q == '0);
    sts_o.brk      = dec.brk;
    sts_o.emit     = dec.emit;
    sts_o.held_vld = held_vld_q;
    sts_o.out_free = !out_vld_q || out_ready_i;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/tksd_ctrl.sv]
// Controller: sequences load, parse steps and the final flush of one input beat.
`timescale 1ns / 1ps

module tksd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tksd_pkg::sts_t sts_i,
  output tksd_pkg::cmd_t cmd_o
);
  import tksd_pkg::*;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StParse = 3'b010,
    StFlush = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] nev_q, nev_d;

  always_comb begin
    state_d    = state_q;
    nev_d      = nev_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          nev_d      = '0;
          state_d    = StParse;
        end
      end
      StParse: begin
        if (sts_i.len_zero || sts_i.brk) begin
          cmd_o.finish = 1'b1;
          state_d      = StFlush;
        end else if (sts_i.emit && nev_q < 3'(MaxEvents)) begin
          if (!sts_i.held_vld || sts_i.out_free) begin
            cmd_o.step    = 1'b1;
            cmd_o.capture = 1'b1;
            cmd_o.move    = sts_i.held_vld;
            nev_d         = nev_q + 3'd1;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StFlush: begin
        if (!sts_i.held_vld) begin
          state_d = StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.move = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      nev_q   <= '0;
    end else begin
      state_q <= state_d;
      nev_q   <= nev_d;
    end
  end

endmodule
